### design/bfa_pkg.sv
package bfa_pkg;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_MUL,
    ST_ADD,
    ST_FREE_RD,
    ST_FREE_WR
  } state_t;

  // result status codes
  localparam logic [2:0] STATUS_ALLOCATED    = 3'd0;
  localparam logic [2:0] STATUS_NO_FRAME     = 3'd1;
  localparam logic [2:0] STATUS_FREED        = 3'd2;
  localparam logic [2:0] STATUS_BELOW_BASE   = 3'd3;
  localparam logic [2:0] STATUS_BEYOND_LIMIT = 3'd4;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // configuration register indexes
  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_TOTAL_FRAMES = 1'b1;

  localparam logic [31:0] WORD_FULL = 32'hFFFF_FFFF;

endpackage

### design/bitmap_frame_allocator.sv
// Allocate: the scan reads bitmap words from the lowest word that may hold a clear bit and
//   skips full words; no free frame is reported at the end of the bitmap, when the word is
//   past the limit, or when only its clear bit is. Free: rejected below base while idle,
//   rejected beyond the limit after the read, else the frame's bit is cleared.
// One request at a time; the next is taken at the edge that takes the result.
// Reset: synchronous; a clearing pass over all BITMAP_WORDS words fills the memory, busy held high.
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int BITMAP_WORDS   = 1024,
  parameter int FRAME_BYTES    = 4096,
  parameter int RESERVED_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] frame_address,
  output logic        done,
  output logic [31:0] alloc_address,
  output logic [2:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW  = $clog2(BITMAP_WORDS);
  localparam int FW  = AW + 5;
  localparam int CAP = BITMAP_WORDS * 32;
  localparam int LW  = $clog2(CAP + 1);
  // frame size is a power of two, so the frame index is a shift of the offset
  localparam int RW  = $clog2(FRAME_BYTES);

  // configuration registers
  logic [31:0] base_address;
  logic [15:0] total_frames;

  // sequencer registers
  state_t        state, state_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic [AW-1:0] hint, hint_next;
  logic [AW:0]   scan_w, scan_w_next;
  logic [FW-1:0] idx, idx_next;
  logic [31:0]   prod, prod_next;
  logic [31:0]   dq, dq_next;
  logic          done_next;
  logic [31:0]   alloc_address_next;
  logic [2:0]    status_next;

  // bitmap memory
  logic [31:0]   bitmap [BITMAP_WORDS];
  logic [31:0]   rdata;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd;

  logic [LW-1:0] eff_frames;
  logic [31:0]   inv, low_zero;
  logic [4:0]    bpos;
  logic [AW-1:0] dq_word;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign dq_word   = dq[AW+4:5];

  // frame count clamped to bitmap capacity
  always_comb begin
    if (32'(total_frames) > 32'(CAP)) begin
      eff_frames = LW'(CAP);
    end else begin
      eff_frames = LW'(total_frames);
    end
  end

  // lowest clear bit of the word read
  always_comb begin
    inv      = ~rdata;
    low_zero = inv & (~inv + 32'd1);
    bpos     = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (low_zero[i]) begin
        bpos = 5'(i);
      end
    end
  end

  // next state, memory controls and result
  always_comb begin
    state_next         = state;
    clr_cnt_next       = clr_cnt;
    hint_next          = hint;
    scan_w_next        = scan_w;
    idx_next           = idx;
    prod_next          = prod;
    dq_next            = dq;
    done_next          = 1'b0;
    alloc_address_next = alloc_address;
    status_next        = status;
    mem_we             = 1'b0;
    mem_wa             = clr_cnt;
    mem_wd             = 32'd0;
    mem_ra             = scan_w[AW-1:0];

    unique case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_wa       = clr_cnt;
        mem_wd       = (32'(clr_cnt) < 32'(RESERVED_WORDS)) ? WORD_FULL : 32'd0;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(BITMAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          if (func == FUNC_ALLOC) begin
            scan_w_next = {1'b0, hint};
            state_next  = ST_SCAN_RD;
          end else if (frame_address < base_address) begin
            done_next          = 1'b1;
            alloc_address_next = 32'd0;
            status_next        = STATUS_BELOW_BASE;
          end else begin
            dq_next    = (frame_address - base_address) >> RW;
            state_next = ST_FREE_RD;
          end
        end
      end

      // stop at the end of the bitmap or once the word lies past the limit
      ST_SCAN_RD: begin
        mem_ra = scan_w[AW-1:0];
        if (scan_w == (AW+1)'(BITMAP_WORDS) ||
            32'({scan_w, 5'd0}) >= 32'(eff_frames)) begin
          done_next          = 1'b1;
          alloc_address_next = 32'd0;
          status_next        = STATUS_NO_FRAME;
          state_next         = ST_IDLE;
        end else begin
          state_next = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (rdata == WORD_FULL) begin
          scan_w_next = scan_w + (AW+1)'(1);
          state_next  = ST_SCAN_RD;
        end else if (32'({scan_w[AW-1:0], bpos}) >= 32'(eff_frames)) begin
          done_next          = 1'b1;
          alloc_address_next = 32'd0;
          status_next        = STATUS_NO_FRAME;
          state_next         = ST_IDLE;
        end else begin
          mem_we     = 1'b1;
          mem_wa     = scan_w[AW-1:0];
          mem_wd     = rdata | low_zero;
          hint_next  = scan_w[AW-1:0];
          idx_next   = {scan_w[AW-1:0], bpos};
          state_next = ST_MUL;
        end
      end

      ST_MUL: begin
        prod_next  = 32'(idx) * 32'(FRAME_BYTES);
        state_next = ST_ADD;
      end

      ST_ADD: begin
        done_next          = 1'b1;
        alloc_address_next = base_address + prod;
        status_next        = STATUS_ALLOCATED;
        state_next         = ST_IDLE;
      end

      // dq now holds the frame index
      ST_FREE_RD: begin
        mem_ra = dq_word;
        if (dq >= 32'(eff_frames)) begin
          done_next          = 1'b1;
          alloc_address_next = 32'd0;
          status_next        = STATUS_BEYOND_LIMIT;
          state_next         = ST_IDLE;
        end else begin
          state_next = ST_FREE_WR;
        end
      end

      ST_FREE_WR: begin
        mem_we             = 1'b1;
        mem_wa             = dq_word;
        mem_wd             = rdata & ~(32'd1 << dq[4:0]);
        done_next          = 1'b1;
        alloc_address_next = 32'd0;
        status_next        = STATUS_FREED;
        state_next         = ST_IDLE;
        if (dq_word < hint) begin
          hint_next = dq_word;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      hint    <= AW'(RESERVED_WORDS);
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      hint    <= hint_next;
      done    <= done_next;
    end
    scan_w        <= scan_w_next;
    idx           <= idx_next;
    prod          <= prod_next;
    dq            <= dq_next;
    alloc_address <= alloc_address_next;
    status        <= status_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= 32'd0;
      total_frames <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_TOTAL_FRAMES: total_frames <= cfg_data[15:0];
      endcase
    end
  end

  // bitmap memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_wa] <= mem_wd;
    end
    rdata <= bitmap[mem_ra];
  end

endmodule

### design/bfa_checker.sv
module bfa_checker
  import bfa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] alloc_address,
  input logic [2:0]  status
);

  // reset starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a taken request either keeps the block busy or answers at once
  a_request_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request taken but neither busy nor answered");

  // every strobe follows a taken request or work in progress
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result without request");

  // only a successful allocate carries an address
  a_zero_address: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_ALLOCATED) |-> (alloc_address == 32'd0))
    else $error("nonzero address on non-allocate result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status <= STATUS_BEYOND_LIMIT))
    else $error("status code out of range");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .alloc_address (alloc_address),
  .status        (status)
);
